// ----- rtl/core/dsp_adpcm_decoder_core_defines.svh -----
// Assertion macros used by the checker file of the ADPCM decoder core.
`ifndef DSP_ADPCM_DECODER_CORE_DEFINES_SVH
`define DSP_ADPCM_DECODER_CORE_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define DAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Hold a signal while a condition stays true across an edge.
`define DAP_ASSERT_HOLD(lbl, cond, sig, msg) \
  `DAP_ASSERT(lbl, (cond) |=> $stable(sig), msg)

`endif

// ----- rtl/core/dap_pkg.sv -----
// Shared constants and types of the ADPCM decoder core.
`default_nettype none
package dap_pkg;

  localparam int SamplesInFrameDef = 14;

  localparam int ByteW      = 8;
  localparam int SampleW    = 16;
  localparam int CoefW      = 16;
  localparam int CountW     = 32;
  localparam int PosW       = 3;
  localparam int NumPairs   = 8;
  localparam int PairIdxW   = 3;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int OutDataW   = 40;
  localparam int AccW       = 35;
  localparam int FracShift  = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEFS_0   = 3'd0,
    CFG_COEFS_1   = 3'd1,
    CFG_COEFS_2   = 3'd2,
    CFG_COEFS_3   = 3'd3,
    CFG_START_H1  = 3'd4,
    CFG_START_H2  = 3'd5,
    CFG_COUNT     = 3'd6
  } cfg_idx_e;

  typedef logic signed [SampleW-1:0] sample_t;

endpackage
`default_nettype wire

// ----- rtl/core/dsp_adpcm_decoder_core.sv -----
// 4-bit DSP ADPCM decoder core: one stream byte in, up to two PCM samples out.
//
// Input words arrive on s_axis: tdata holds the stream byte, tuser marks the first byte
// of a stream (reload history and sample count, byte is a frame header). Each frame is
// one header byte (predictor in the high nibble, scale in the low nibble) and then data
// bytes, each giving two samples, high nibble first.
// Output words leave on m_axis: tdata holds sample, previous sample and frame header;
// tlast marks the final sample of the configured count.
// Registers are written over the cfg channel (always ready); the user must write them
// only while the core is idle, which the core does not enforce. Each accepted byte waits
// in the input register until done, and the next byte can enter as it finishes; its
// samples are registered in the output register by the single prediction unit (two
// 16x16 multipliers and one accumulate), one sample per cycle while m_axis is not stalled.
// Reset clears all registers, history and count; bytes are dropped until a word with
// tuser set loads a nonzero count.
// When m_axis stalls, the output register holds its word and s_axis_tready drops once
// the byte in the input register needs the output.
`default_nettype none
module dsp_adpcm_decoder_core import dap_pkg::*; #(
  parameter int SAMPLES_IN_FRAME = SamplesInFrameDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  wire logic                s_axis_tuser,   // [0] first
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,   // [15:0] sample, [31:16] previous_sample,
                                                   // [39:32] header
  output      logic                m_axis_tlast    // last
);

  localparam logic [3:0] FrameLen = 4'(SAMPLES_IN_FRAME);

  logic [2*CoefW-1:0]  coef_pair_q [NumPairs];
  sample_t             start_h1_q, start_h2_q;
  logic [CountW-1:0]   count_q;

  logic                in_valid_q;
  logic [ByteW-1:0]    in_byte_q;
  logic                in_first_q;
  logic                phase_q;

  sample_t             hist1_q, hist2_q;
  logic [ByteW-1:0]    header_q;
  logic [PosW-1:0]     pos_q;
  logic [CountW-1:0]   left_q;

  logic                out_valid_q;
  sample_t             out_sample_q, out_prev_q;
  logic [ByteW-1:0]    out_header_q;
  logic                out_last_q;

  logic                use_first;
  sample_t             h1_e, h2_e;
  logic [CountW-1:0]   left_e, left_dec;
  logic [PosW-1:0]     pos_e, pos_next;
  logic                drop, is_header, emit, need_second, last_phase;
  logic                out_free, step_go, in_done;
  logic [3:0]          nib;
  logic signed [3:0]   nib_s;
  logic [2*CoefW-1:0]  pair;
  logic signed [CoefW-1:0] coef_a, coef_b;
  logic signed [2*CoefW-1:0] prod_a, prod_b;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-FracShift-1:0] acc_sh;
  sample_t             sample_c;

  assign cfg_ready_o = 1'b1;

  assign use_first = in_first_q & ~phase_q;
  assign h1_e      = use_first ? start_h1_q : hist1_q;
  assign h2_e      = use_first ? start_h2_q : hist2_q;
  assign left_e    = use_first ? count_q : left_q;
  assign pos_e     = use_first ? '0 : pos_q;
  assign left_dec  = left_e - CountW'(1);

  assign drop      = (left_e == '0);
  assign is_header = (pos_e == '0);
  assign emit      = in_valid_q & ~drop & ~is_header;

  assign need_second = (left_dec != '0) && ({pos_e - PosW'(1), 1'b1} < FrameLen);
  assign last_phase  = phase_q | ~need_second;
  assign pos_next    = ({pos_e, 1'b0} >= FrameLen) ? '0 : pos_e + PosW'(1);

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign step_go       = in_valid_q & (~emit | out_free);
  assign in_done       = step_go & (~emit | last_phase);
  assign s_axis_tready = ~in_valid_q | in_done;

  assign nib    = phase_q ? in_byte_q[3:0] : in_byte_q[7:4];
  assign nib_s  = signed'(nib);
  assign pair   = coef_pair_q[header_q[6:4]];
  assign coef_a = signed'(pair[CoefW-1:0]);
  assign coef_b = signed'(pair[2*CoefW-1:CoefW]);
  assign prod_a = coef_a * h1_e;
  assign prod_b = coef_b * h2_e;

  always_comb begin
    acc = (AccW'(nib_s) <<< (6'(header_q[3:0]) + 6'(FracShift)))
        + AccW'(1024) + AccW'(prod_a) + AccW'(prod_b);
    acc_sh = (AccW-FracShift)'(acc >>> FracShift);
    if (acc_sh > (AccW-FracShift)'(32767)) begin
      sample_c = 16'sh7FFF;
    end else if (acc_sh < -(AccW-FracShift)'(32768)) begin
      sample_c = -16'sh8000;
    end else begin
      sample_c = SampleW'(acc_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPairs; i++) begin
        coef_pair_q[i] <= '0;
      end
      start_h1_q   <= '0;
      start_h2_q   <= '0;
      count_q      <= '0;
      in_valid_q   <= 1'b0;
      in_byte_q    <= '0;
      in_first_q   <= 1'b0;
      phase_q      <= 1'b0;
      hist1_q      <= '0;
      hist2_q      <= '0;
      header_q     <= '0;
      pos_q        <= '0;
      left_q       <= '0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_prev_q   <= '0;
      out_header_q <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_COEFS_0, CFG_COEFS_1, CFG_COEFS_2, CFG_COEFS_3: begin
            coef_pair_q[{cfg_index_i[1:0], 1'b0}] <= cfg_data_i[2*CoefW-1:0];
            coef_pair_q[{cfg_index_i[1:0], 1'b1}] <= cfg_data_i[CfgDataW-1:2*CoefW];
          end
          CFG_START_H1: start_h1_q <= signed'(cfg_data_i[SampleW-1:0]);
          CFG_START_H2: start_h2_q <= signed'(cfg_data_i[SampleW-1:0]);
          CFG_COUNT:    count_q    <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end

      if (step_go) begin
        if (drop) begin
          hist1_q <= h1_e;
          hist2_q <= h2_e;
          left_q  <= left_e;
          pos_q   <= pos_e;
          phase_q <= 1'b0;
        end else if (is_header) begin
          hist1_q  <= h1_e;
          hist2_q  <= h2_e;
          left_q   <= left_e;
          header_q <= in_byte_q;
          pos_q    <= PosW'(1);
          phase_q  <= 1'b0;
        end else begin
          hist2_q <= h1_e;
          hist1_q <= sample_c;
          left_q  <= left_dec;
          if (last_phase) begin
            pos_q   <= pos_next;
            phase_q <= 1'b0;
          end else begin
            pos_q   <= pos_e;
            phase_q <= 1'b1;
          end
        end
      end

      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
        if (s_axis_tvalid) begin
          in_byte_q  <= s_axis_tdata;
          in_first_q <= s_axis_tuser;
        end
      end

      if (out_free) begin
        out_valid_q <= emit;
        if (emit) begin
          out_sample_q <= sample_c;
          out_prev_q   <= h1_e;
          out_header_q <= header_q;
          out_last_q   <= (left_dec == '0);
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_header_q, out_prev_q, out_sample_q};
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// ----- rtl/core/dap_checker.sv -----
// Port-level checker of the ADPCM decoder core and its bind.
`default_nettype none
`include "dsp_adpcm_decoder_core_defines.svh"
module dap_checker import dap_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                cfg_valid_i,
  input wire logic                cfg_ready_o,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  `DAP_ASSERT(a_out_valid_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "valid drop")
  `DAP_ASSERT_HOLD(a_out_word_hold, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "word moved")
  `DAP_ASSERT(a_stall_needs_output, (!s_axis_tready ##1 !s_axis_tready) |-> m_axis_tvalid, "stall")
  `DAP_ASSERT(a_cfg_always_ready, cfg_valid_i |-> cfg_ready_o, "cfg write refused")

endmodule

bind dsp_adpcm_decoder_core dap_checker u_dap_checker (.*);
`default_nettype wire

// ----- sim/tb_dsp_adpcm_decoder_core.sv -----
// Self-checking testbench for the 4-bit ADPCM decoder core with a built-in sample predictor.
module tb_dsp_adpcm_decoder_core;
  import dap_pkg::*;

  localparam int FrameSamples = SamplesInFrameDef;
  localparam int DataBytes    = (FrameSamples + 1) / 2;
  localparam int RandItems    = 1550;
  localparam int HoldCycles   = 250;
  localparam int SettleCycles = 20;
  localparam int DrainGuard   = 20000;

  typedef struct {
    logic [ByteW-1:0] b;
    logic             f;
  } stream_byte_t;

  typedef struct {
    sample_t          smp;
    sample_t          prev;
    logic [ByteW-1:0] hdr;
    logic             last;
  } pcm_word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  dsp_adpcm_decoder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // decoder shadow state and register copies
  logic [CfgDataW-1:0] coef_reg [4];
  sample_t             start_h1;
  sample_t             start_h2;
  logic [CountW-1:0]   count_reg;
  sample_t             hist1;
  sample_t             hist2;
  logic [ByteW-1:0]    cur_hdr;
  int unsigned         byte_pos;
  logic [CountW-1:0]   left_cnt;

  stream_byte_t byte_q [$];
  pcm_word_t    pcm_q [$];

  int  errs      = 0;
  int  n_rand    = 0;
  int  n_bytes   = 0;
  int  n_acc     = 0;
  int  n_chk     = 0;
  int  n_phases  = 0;
  bit  calm      = 1'b0;
  bit  stall_req = 1'b0;
  int  hold_left = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1600000;
    $display("timeout at %0t", $time);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < 10);
  endfunction

  function automatic sample_t predict_nibble(logic [3:0] nib);
    int      pair;
    int      nib_val;
    sample_t c1;
    sample_t c2;
    longint  acc;
    longint  r;
    pair    = int'(cur_hdr[6:4]);
    c1      = coef_reg[pair / 2][(pair % 2) * 32 +: 16];
    c2      = coef_reg[pair / 2][(pair % 2) * 32 + 16 +: 16];
    nib_val = nib[3] ? int'(nib) - 16 : int'(nib);
    acc = longint'(nib_val) * (longint'(1) << cur_hdr[3:0]) * 2048 + 1024
          + longint'(c1) * longint'(hist1) + longint'(c2) * longint'(hist2);
    r = acc >>> FracShift;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    hist2 = hist1;
    hist1 = sample_t'(r);
    return sample_t'(r);
  endfunction

  function automatic void decode_byte(logic [ByteW-1:0] b, logic f);
    int unsigned base;
    pcm_word_t   w;
    logic [3:0]  nib;
    if (f) begin
      hist1    = start_h1;
      hist2    = start_h2;
      left_cnt = count_reg;
      byte_pos = 0;
    end
    if (left_cnt == 0) return;
    if (byte_pos == 0) begin
      cur_hdr  = b;
      byte_pos = 1;
      return;
    end
    base = (byte_pos - 1) * 2;
    for (int k = 0; k < 2; k++) begin
      if (left_cnt == 0 || base + k >= FrameSamples) break;
      nib      = (k == 0) ? b[7:4] : b[3:0];
      w.smp    = predict_nibble(nib);
      left_cnt = left_cnt - 1;
      w.prev   = hist2;
      w.hdr    = cur_hdr;
      w.last   = (left_cnt == 0);
      pcm_q.push_back(w);
    end
    if (byte_pos * 2 >= FrameSamples) byte_pos = 0;
    else byte_pos = (byte_pos + 1) & 7;
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_bytes
    stream_byte_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tuser);
        n_acc++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_q.size() != 0 && !idle_roll()) begin
          nxt = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.b;
          s_axis_tuser  <= nxt.f;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin : hold_off
    if (stall_req) begin
      hold_left = HoldCycles;
      stall_req = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_samples
    pcm_word_t want;
    pcm_word_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.smp  = m_axis_tdata[15:0];
      got.prev = m_axis_tdata[31:16];
      got.hdr  = m_axis_tdata[39:32];
      got.last = m_axis_tlast;
      n_chk++;
      if (pcm_q.size() == 0) begin
        errs++;
        $display("%0t: unexpected word, got sample %0d prev %0d hdr %h last %b",
                 $time, got.smp, got.prev, got.hdr, got.last);
      end else begin
        want = pcm_q.pop_front();
        if (got.smp !== want.smp) begin
          errs++;
          $display("%0t: sample expected %0d got %0d", $time, want.smp, got.smp);
        end
        if (got.prev !== want.prev) begin
          errs++;
          $display("%0t: previous_sample expected %0d got %0d", $time, want.prev, got.prev);
        end
        if (got.hdr !== want.hdr) begin
          errs++;
          $display("%0t: header expected %h got %h", $time, want.hdr, got.hdr);
        end
        if (got.last !== want.last) begin
          errs++;
          $display("%0t: last expected %b got %b", $time, want.last, got.last);
        end
      end
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !idle_roll();
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_COEFS_0:  coef_reg[0] = val;
      CFG_COEFS_1:  coef_reg[1] = val;
      CFG_COEFS_2:  coef_reg[2] = val;
      CFG_COEFS_3:  coef_reg[3] = val;
      CFG_START_H1: start_h1    = val[15:0];
      CFG_START_H2: start_h2    = val[15:0];
      CFG_COUNT:    count_reg   = val[31:0];
      default: ;
    endcase
  endtask

  task automatic push_byte(logic [ByteW-1:0] b, logic f, bit counted);
    stream_byte_t it;
    it.b = b;
    it.f = f;
    byte_q.push_back(it);
    n_bytes++;
    if (counted) n_rand++;
  endtask

  function automatic logic [ByteW-1:0] rnd_header();
    logic [ByteW-1:0] h;
    h = ByteW'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 7) h[3:0] = 4'($urandom_range(0, 8));
    return h;
  endfunction

  function automatic logic [CfgDataW-1:0] rnd_coefs();
    logic [CfgDataW-1:0] v;
    int unsigned         pick;
    for (int i = 0; i < 4; i++) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0:       v[i*16 +: 16] = 16'h8000;
        1:       v[i*16 +: 16] = 16'h7FFF;
        2, 3:    v[i*16 +: 16] = 16'($urandom_range(0, 65535));
        default: v[i*16 +: 16] = 16'($signed($urandom_range(0, 8191)) - 4096);
      endcase
    end
    return v;
  endfunction

  task automatic add_stream(int unsigned nsamp, int unsigned max_bytes, bit counted);
    int unsigned done;
    int unsigned pos;
    int unsigned nb;
    done = 0;
    pos  = 0;
    nb   = 1;
    push_byte(rnd_header(), 1'b1, counted);
    while (done < nsamp && nb < max_bytes) begin
      if (pos == DataBytes) begin
        push_byte(rnd_header(), 1'b0, counted);
        pos = 0;
      end else begin
        push_byte(ByteW'($urandom_range(0, 255)), 1'b0, counted);
        done += 2;
        pos++;
      end
      nb++;
    end
  endtask

  // wait for the core to go idle, then let it settle
  task automatic drain();
    int guard;
    guard = 0;
    while ((byte_q.size() != 0 || s_axis_tvalid || pcm_q.size() != 0)
           && guard < DrainGuard) begin
      @(negedge clk_i);
      guard++;
    end
    if (pcm_q.size() != 0) begin
      errs++;
      $display("%0t: %0d expected words never arrived", $time, pcm_q.size());
      pcm_q.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_random();
    int unsigned pick;
    logic [CountW-1:0] cnt;
    write_reg(CFG_COEFS_0, rnd_coefs());
    write_reg(CFG_COEFS_1, rnd_coefs());
    write_reg(CFG_COEFS_2, rnd_coefs());
    write_reg(CFG_COEFS_3, rnd_coefs());
    write_reg(CFG_START_H1, CfgDataW'($urandom_range(0, 65535)));
    write_reg(CFG_START_H2, CfgDataW'($urandom_range(0, 65535)));
    pick = $urandom_range(0, 19);
    if (pick == 0) cnt = '0;
    else if (pick == 1) cnt = '1;
    else if (pick == 2) cnt = CountW'($urandom);
    else cnt = CountW'($urandom_range(1, 40));
    write_reg(CFG_COUNT, CfgDataW'(cnt));
  endtask

  initial begin : run
    int unsigned nstreams;
    coef_reg  = '{default: '0};
    start_h1  = '0;
    start_h2  = '0;
    count_reg = '0;
    hist1     = '0;
    hist2     = '0;
    cur_hdr   = '0;
    byte_pos  = 0;
    left_cnt  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extreme coefficients and history, count ends mid-byte, bytes past the count
    write_reg(CFG_COEFS_0, 64'h1234_F800_8000_7FFF);
    write_reg(CFG_COEFS_1, 64'h7FFF_7FFF_8000_8000);
    write_reg(CFG_COEFS_2, 64'h0000_0000_FFFF_0001);
    write_reg(CFG_COEFS_3, 64'h8000_7FFF_0800_F000);
    write_reg(CFG_START_H1, 64'h0000_0000_0000_7FFF);
    write_reg(CFG_START_H2, 64'hFFFF_FFFF_FFFF_8000);
    write_reg(CFG_COUNT, 64'd13);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h80, 1'b0, 1'b1);
    push_byte(8'h7F, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'h88, 1'b0, 1'b1);
    push_byte(8'h77, 1'b0, 1'b1);
    push_byte(8'h19, 1'b0, 1'b1);
    push_byte(8'h12, 1'b0, 1'b0);
    push_byte(8'h34, 1'b0, 1'b0);
    push_byte(8'h8C, 1'b1, 1'b1);
    push_byte(8'h7F, 1'b0, 1'b1);
    push_byte(8'h80, 1'b0, 1'b1);
    push_byte(8'h0F, 1'b1, 1'b1);
    push_byte(8'hA5, 1'b0, 1'b1);
    drain();
    n_phases++;

    // zero count drops the stream, then a count of one
    write_reg(CFG_COEFS_0, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(CFG_START_H1, 64'd0);
    write_reg(CFG_START_H2, 64'd0);
    write_reg(CFG_COUNT, 64'd0);
    push_byte(8'h70, 1'b1, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b0);
    drain();
    write_reg(CFG_COUNT, 64'd1);
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hF7, 1'b0, 1'b1);
    push_byte(8'h55, 1'b0, 1'b0);
    drain();
    n_phases++;

    n_rand = 0;
    while (n_rand < RandItems) begin
      calm = (n_phases == 4);
      program_random();
      nstreams = $urandom_range(3, 7);
      repeat (nstreams) begin
        if ($urandom_range(0, 9) == 0)
          add_stream(count_reg, $urandom_range(2, 12), count_reg != 0);
        else
          add_stream(count_reg, 60, count_reg != 0);
        repeat ($urandom_range(0, 2)) push_byte(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      if (n_phases == 3) stall_req = 1'b1;
      drain();
      n_phases++;
    end
    calm = 1'b0;
    drain();

    $display("bytes offered: %0d, accepted: %0d (%0d random), samples checked: %0d",
             n_bytes, n_acc, n_rand, n_chk);
    $display("register settings: %0d, one long output hold-off included", n_phases);
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
